[hw/rtl/efb_pkg.sv]
// ----------------------------------------------------------------------------
// efb_pkg: shared types and constants of the Ethernet frame builder
// Beat types, configuration indexes, microcode word and control/status
// bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package efb_pkg;

  localparam int unsigned MAX_PAYLOAD = 1500;
  localparam int unsigned MIN_PAYLOAD = 46;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned ETYPE_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned HDR_BYTES   = 14;
  localparam int unsigned PC_W        = 5;
  localparam int unsigned IDX_W       = 4;

  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ETHER_TYPE = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } frame_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_out_t;

  // byte source of a step
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_HDR,
    SRC_DATA,
    SRC_ZERO,
    SRC_FCS
  } src_e;

  // condition that gates emit, count and loop
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_LT_MAX,
    COND_LT_MIN
  } cond_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_IF_FRAME,
    JMP_IF_NOT_LAST,
    JMP_IF_COND
  } jmp_e;

  typedef struct packed {
    logic            accept;
    src_e            src;
    logic [IDX_W-1:0] idx;
    cond_e           cond;
    logic            cnt_inc;
    logic            crc_en;
    logic            set_frame;
    logic            frame_end;
    logic            clear;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   go;
  } ctrl_t;

  typedef struct packed {
    logic in_frame;
    logic last;
    logic cond_ok;
    logic out_ready;
  } status_t;

  function automatic logic [31:0] bit_rev32(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  localparam logic [31:0] CRC_POLY_REFL = bit_rev32(CRC_POLY);

endpackage

[hw/rtl/efb_useq.sv]
// ----------------------------------------------------------------------------
// efb_useq: microcode sequencer
// Step counter over a small control store; one control word per step,
// conditional jumps on frame state, last flag and datapath condition.
// ----------------------------------------------------------------------------
module efb_useq
  import efb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam logic [PC_W-1:0] PC_WAIT     = 5'd0;
  localparam logic [PC_W-1:0] PC_HDR0     = 5'd1;
  localparam logic [PC_W-1:0] PC_HDR_LAST = 5'd14;
  localparam logic [PC_W-1:0] PC_PAY      = 5'd15;
  localparam logic [PC_W-1:0] PC_PAD      = 5'd16;
  localparam logic [PC_W-1:0] PC_FCS0     = 5'd17;
  localparam logic [PC_W-1:0] PC_FCS_LAST = 5'd20;

  function automatic uword_t rom_word(logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    priority if (pc == PC_WAIT) begin
      w.accept = 1'b1;
      w.jmp    = JMP_IF_FRAME;
      w.target = PC_PAY;
    end else if (pc >= PC_HDR0 && pc <= PC_HDR_LAST) begin
      w.src       = SRC_HDR;
      w.idx       = IDX_W'(pc - PC_HDR0);
      w.crc_en    = 1'b1;
      w.set_frame = (pc == PC_HDR_LAST);
    end else if (pc == PC_PAY) begin
      w.src     = SRC_DATA;
      w.cond    = COND_LT_MAX;
      w.cnt_inc = 1'b1;
      w.crc_en  = 1'b1;
      w.jmp     = JMP_IF_NOT_LAST;
      w.target  = PC_WAIT;
    end else if (pc == PC_PAD) begin
      w.src     = SRC_ZERO;
      w.cond    = COND_LT_MIN;
      w.cnt_inc = 1'b1;
      w.crc_en  = 1'b1;
      w.jmp     = JMP_IF_COND;
      w.target  = PC_PAD;
    end else if (pc >= PC_FCS0 && pc <= PC_FCS_LAST) begin
      w.src       = SRC_FCS;
      w.idx       = IDX_W'(pc - PC_FCS0);
      w.frame_end = (pc == PC_FCS_LAST);
      w.clear     = (pc == PC_FCS_LAST);
      w.jmp       = (pc == PC_FCS_LAST) ? JMP_GOTO : JMP_NEXT;
      w.target    = PC_WAIT;
    end else begin
      w.jmp    = JMP_GOTO;
      w.target = PC_WAIT;
    end
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            go;
  logic            taken;

  assign uw = rom_word(pc_q);

  always_comb begin
    priority if (uw.accept) begin
      go = in_valid_i;
    end else if (uw.src != SRC_NONE && status_i.cond_ok) begin
      go = status_i.out_ready;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    unique case (uw.jmp)
      JMP_NEXT:        taken = 1'b0;
      JMP_GOTO:        taken = 1'b1;
      JMP_IF_FRAME:    taken = status_i.in_frame;
      JMP_IF_NOT_LAST: taken = !status_i.last;
      JMP_IF_COND:     taken = status_i.cond_ok;
      default:         taken = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      pc_d = taken ? uw.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_stall_o = !uw.accept;
  assign ctrl_o     = '{uw: uw, go: go};

`ifndef ASSERT_OFF
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_FCS_LAST)
    else $error("sequencer step out of program");

  a_resume_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_WAIT && in_valid_i && status_i.in_frame) |=> pc_q == PC_PAY)
    else $error("mid-frame beat did not go to payload step");

  a_end_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && uw.frame_end) |=> pc_q == PC_WAIT)
    else $error("frame end did not return to wait step");
`endif

endmodule

[hw/rtl/efb_dpath.sv]
// ----------------------------------------------------------------------------
// efb_dpath: frame builder datapath
// Config registers, input latch, byte mux, CRC-32 register, payload
// counter and the output register.
// ----------------------------------------------------------------------------
module efb_dpath
  import efb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  frame_in_t            in_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output frame_out_t           out_data_o,
  input  ctrl_t                ctrl_i,
  output status_t              status_o
);

  // one byte into the reflected CRC, lsb first
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  logic [MAC_W-1:0]   dest_q, src_q;
  logic [ETYPE_W-1:0] etype_q;
  frame_in_t          in_q;
  logic [31:0]        crc_q, crc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               in_frame_q, in_frame_d;
  logic               out_valid_q, out_valid_d;
  frame_out_t         out_q, out_d;

  uword_t                        uw;
  logic                          cond_ok, emit, accept, out_ready;
  logic [8*HDR_BYTES-1:0]        hdr_sh;
  logic [31:0]                   fcs_sh;
  logic [7:0]                    byte_sel;

  assign uw        = ctrl_i.uw;
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_LT_MAX: cond_ok = cnt_q < CNT_W'(MAX_PAYLOAD);
      COND_LT_MIN: cond_ok = cnt_q < CNT_W'(MIN_PAYLOAD);
      default:     cond_ok = 1'b0;
    endcase
  end

  assign emit   = ctrl_i.go && uw.src != SRC_NONE && cond_ok;
  assign accept = ctrl_i.go && uw.accept;

  assign hdr_sh = {dest_q, src_q, etype_q} << {uw.idx, 3'b000};
  assign fcs_sh = ~crc_q >> {uw.idx[1:0], 3'b000};

  always_comb begin
    unique case (uw.src)
      SRC_HDR:  byte_sel = hdr_sh[8*HDR_BYTES-1 -: 8];
      SRC_DATA: byte_sel = in_q.payload_byte;
      SRC_FCS:  byte_sel = fcs_sh[7:0];
      default:  byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    in_frame_d  = in_frame_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = '{frame_byte: byte_sel, frame_end: uw.frame_end};
      if (uw.crc_en) begin
        crc_d = crc_byte(crc_q, byte_sel);
      end
      if (uw.cnt_inc) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (ctrl_i.go && uw.set_frame) begin
      in_frame_d = 1'b1;
    end
    // close the frame: back to reset values
    if (ctrl_i.go && uw.clear) begin
      crc_d      = CRC_INIT;
      cnt_d      = '0;
      in_frame_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q      <= '0;
      src_q       <= '0;
      etype_q     <= '0;
      crc_q       <= CRC_INIT;
      cnt_q       <= '0;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      in_frame_q  <= in_frame_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEST_MAC:   dest_q  <= cfg_wdata_i;
          CFG_SRC_MAC:    src_q   <= cfg_wdata_i;
          CFG_ETHER_TYPE: etype_q <= cfg_wdata_i[ETYPE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign status_o    = '{in_frame: in_frame_q, last: in_q.last_byte,
                         cond_ok: cond_ok, out_ready: out_ready};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count above maximum");

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> cnt_q == '0)
    else $error("payload counted outside a frame");

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.go && uw.clear) |=> (crc_q == CRC_INIT && cnt_q == '0 && !in_frame_q))
    else $error("frame state not cleared after FCS");

  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && uw.frame_end) |=> (out_valid_q && out_q.frame_end))
    else $error("last FCS byte not marked as frame end");
`endif

endmodule

[hw/rtl/ethernet_frame_builder_fcs_top.sv]
// ----------------------------------------------------------------------------
// ethernet_frame_builder_fcs_top: Ethernet frame builder with CRC-32 FCS
// Turns a stream of payload bytes into complete frames in wire order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one payload
//   byte per beat, with last_byte on the final byte of a frame. The first
//   beat of a frame emits the 14-byte header (dest MAC, src MAC, ethertype,
//   all high byte first) from the config registers, then the byte itself.
//   Bytes past 1500 are dropped. The last beat adds zero padding up to 46
//   payload bytes and the 4-byte FCS, lsb first; frame_end marks its last
//   byte. Output channel (out_valid_o / out_stall_i / out_data_o) moves one
//   frame byte per beat out of a single output register.
//   Sequencing: a beat is taken in the sequencer's wait step; each produced
//   byte is a step of the step counter, and the pad step ends with a step
//   that emits no byte, for its exit test. The byte of each step is
//   registered in the output register, which the first byte reaches once
//   the sequencer has left the wait step. A stalled receiver holds the
//   output register and freezes the sequencer on its next byte step.
//   Reset clears config registers to zero, the CRC to all ones, the count
//   and the frame flag; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module ethernet_frame_builder_fcs_top
  import efb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  frame_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output frame_out_t           out_data_o
);

  ctrl_t   ctrl;
  status_t status;

  efb_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  efb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ethernet_frame_builder_fcs_top
// Feeds payload beats grouped into frames, predicts every frame byte
// (header, payload, zero padding, CRC-32 FCS) with a local model and checks
// the output stream byte by byte under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import efb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [31:0] CRC_POLY_LSB_FIRST = 32'hEDB88320;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [MAC_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  frame_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  frame_out_t           out_data;

  ethernet_frame_builder_fcs_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending payload beats and expected frame bytes
  frame_in_t  payload_feed[$];
  frame_out_t frame_exp[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_fire = 1'b0;
  int quiet_cycles = 0;
  int mismatch_cnt = 0;
  int beats_sent = 0;
  int frames_queued = 0;
  int bytes_checked = 0;

  // local copy of the frame builder state and registers
  logic [31:0]      mdl_crc = 32'hFFFF_FFFF;
  logic [CNT_W-1:0] mdl_count = '0;
  logic             mdl_in_frame = 1'b0;
  logic [MAC_W-1:0] mdl_dest = '0;
  logic [MAC_W-1:0] mdl_src = '0;
  logic [ETYPE_W-1:0] mdl_etype = '0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_LSB_FIRST) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_frame_byte(input logic [7:0] b, input logic with_crc, input logic fin);
    frame_out_t o;
    o.frame_byte = b;
    o.frame_end  = fin;
    frame_exp.insert(frame_exp.size(), o);
    if (with_crc) mdl_crc = crc_byte(mdl_crc, b);
  endtask

  task automatic predict_frame_bytes(input frame_in_t beat);
    logic [31:0] fcs;
    if (!mdl_in_frame) begin
      for (int k = 5; k >= 0; k--) push_frame_byte(mdl_dest[8*k +: 8], 1'b1, 1'b0);
      for (int k = 5; k >= 0; k--) push_frame_byte(mdl_src[8*k +: 8], 1'b1, 1'b0);
      push_frame_byte(mdl_etype[15:8], 1'b1, 1'b0);
      push_frame_byte(mdl_etype[7:0], 1'b1, 1'b0);
      mdl_in_frame = 1'b1;
    end
    // drop payload past the maximum
    if (mdl_count < MAX_PAYLOAD) begin
      push_frame_byte(beat.payload_byte, 1'b1, 1'b0);
      mdl_count = mdl_count + 1'b1;
    end
    if (beat.last_byte) begin
      while (mdl_count < MIN_PAYLOAD) begin
        push_frame_byte(8'h00, 1'b1, 1'b0);
        mdl_count = mdl_count + 1'b1;
      end
      fcs = ~mdl_crc;
      for (int k = 0; k < 4; k++) push_frame_byte(fcs[8*k +: 8], 1'b0, k == 3);
      mdl_crc = 32'hFFFF_FFFF;
      mdl_count = '0;
      mdl_in_frame = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // sender: hold a stalled beat, otherwise advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (payload_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= payload_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : mon
    frame_out_t want;
    logic busy;
    if (rst_n) begin
      busy = 1'b0;
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_frame_bytes(in_data);
        beats_sent++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (frame_exp.size() == 0) begin
          note_mismatch($sformatf("unexpected frame byte %02h end %0b",
                                  out_data.frame_byte, out_data.frame_end));
        end else begin
          want = frame_exp.pop_front();
          bytes_checked++;
          if (out_data.frame_byte !== want.frame_byte ||
              out_data.frame_end !== want.frame_end) begin
            note_mismatch($sformatf("byte %0d: expected %02h end %0b, got %02h end %0b",
                                    bytes_checked, want.frame_byte, want.frame_end,
                                    out_data.frame_byte, out_data.frame_end));
          end
        end
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEST_MAC:   mdl_dest = val;
      CFG_SRC_MAC:    mdl_src = val;
      CFG_ETHER_TYPE: mdl_etype = val[ETYPE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_header(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                            input logic [ETYPE_W-1:0] et);
    write_reg(CFG_DEST_MAC, dst);
    write_reg(CFG_SRC_MAC, src);
    write_reg(CFG_ETHER_TYPE, {32'hDEAD_BEEF, et});
  endtask

  task automatic queue_beat(input logic [7:0] b, input logic fin);
    frame_in_t beat;
    beat.payload_byte = b;
    beat.last_byte    = fin;
    payload_feed.insert(payload_feed.size(), beat);
    if (fin) frames_queued++;
  endtask

  task automatic queue_frame(input int len);
    for (int i = 0; i < len; i++) queue_beat(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // mostly short frames, some around the padding boundary, a few longer
  task automatic queue_random_frames(input int n_items);
    int queued;
    int len;
    int pick;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      len = $urandom_range(1, 20);
      else if (pick < 8) len = $urandom_range(MIN_PAYLOAD - 3, MIN_PAYLOAD + 3);
      else               len = $urandom_range(MIN_PAYLOAD + 4, 80);
      // trim the closing frame to the phase budget
      if (len > n_items - queued) len = n_items - queued;
      queue_frame(len);
      queued += len;
    end
  endtask

  // wait for all beats to go in and all frame bytes to come out
  task automatic drain;
    while (payload_feed.size() != 0 || in_valid || frame_exp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_random_header;
    set_header({16'($urandom), $urandom}, {16'($urandom), $urandom}, 16'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-byte frame with the reset header
    queue_beat(8'h00, 1'b1);
    drain();
    set_header({MAC_W{1'b1}}, {MAC_W{1'b1}}, {ETYPE_W{1'b1}});
    write_reg(CFG_UNUSED, 48'h1234_5678_9ABC);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h80, 1'b0);
    queue_beat(8'h01, 1'b0);
    queue_beat(8'h7F, 1'b1);
    queue_beat(8'hAA, 1'b0);
    queue_beat(8'h55, 1'b0);
    drain();
    // header change mid-frame applies from the next frame only
    set_header(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'h0800);
    queue_beat(8'h5A, 1'b1);
    queue_beat(8'hC3, 1'b1);
    drain();

    set_random_header();
    queue_random_frames(ITEMS_PER_PHASE);
    drain();

    set_header(48'h0000_0000_0001, 48'h8000_0000_0000, 16'h8100);
    send_idle_pct = 78;
    queue_random_frames(ITEMS_PER_PHASE / 2);
    drain();
    queue_random_frames(ITEMS_PER_PHASE / 2);
    drain();

    set_random_header();
    send_idle_pct = 0;
    recv_stall_pct = 78;
    queue_random_frames(ITEMS_PER_PHASE);
    drain();

    set_random_header();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    queue_random_frames(ITEMS_PER_PHASE);
    drain();

    $display("summary: %0d payload beats in %0d frames, %0d frame bytes checked, %0d mismatches",
             beats_sent, frames_queued, bytes_checked, mismatch_cnt);
    $display("summary: short and padded frames under idle and stall mixes");
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
